/* rtl/ihds_pkg.sv */
// ----------------------------------------------------------------------------
// ihds_pkg
// Types and constants for the image header dimension sniffer.
// ----------------------------------------------------------------------------
package ihds_pkg;

   // Number of leading file bytes kept for the signature and dimension checks
   localparam int HEADER_BYTES = 30;

   // JPEG marker bytes
   localparam logic [7:0] MARKER_PREFIX = 8'hFF;
   localparam logic [7:0] MARKER_SOI    = 8'hD8;
   localparam logic [7:0] MARKER_EOI    = 8'hD9;
   localparam logic [7:0] MARKER_DHT    = 8'hC4;
   localparam logic [7:0] MARKER_JPG    = 8'hC8;
   localparam logic [7:0] MARKER_DAC    = 8'hCC;

   // Result status codes
   typedef enum logic [2:0] {
      STATUS_OK          = 3'd0,
      STATUS_EMPTY       = 3'd1,
      STATUS_PNG_ZERO    = 3'd2,
      STATUS_GIF_ZERO    = 3'd3,
      STATUS_JPEG_ZERO   = 3'd4,
      STATUS_UNPARSED    = 3'd5,
      STATUS_UNSUPPORTED = 3'd6
   } status_type;

   // JPEG marker and segment walker phases
   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_SEARCH = 3'd1,
      PH_FFRUN  = 3'd2,
      PH_LENHI  = 3'd3,
      PH_LENLO  = 3'd4,
      PH_SKIP   = 3'd5,
      PH_SOF    = 3'd6,
      PH_DONE   = 3'd7
   } jpeg_phase_type;

   // What the JPEG walk has found so far
   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_OK   = 2'd1,
      KIND_ZERO = 2'd2
   } jpeg_kind_type;

   // Start-of-frame markers: C0..CF except DHT, JPG and DAC
   function automatic logic is_sof(input logic [7:0] m);
      logic r;
      r = (m[7:4] == 4'hC);
      case (m)
         MARKER_DHT, MARKER_JPG, MARKER_DAC: r = 1'b0;
         default: ;
      endcase
      return r;
   endfunction

endpackage

/* rtl/image_header_dimension_sniffer_core.sv */
// ----------------------------------------------------------------------------
// image_header_dimension_sniffer_core
// Reads width and height from PNG, GIF, WebP (VP8X) and JPEG file headers.
// ----------------------------------------------------------------------------
// Usage:
//   Stream a file in, one byte per req transaction, from offset zero. Every
//   transaction carries the total file length and the supported-media-type
//   flag; both are taken from the first byte of each file only. A file of
//   length zero is sent as one lone transaction and yields the empty status.
//   Exactly one rsp transaction follows the final byte of each file: status,
//   width and height (width and height read zero unless status is OK).
//   Formats are checked in the order PNG, GIF, WebP VP8X, then the JPEG SOF
//   segment found by the marker walker that runs as the bytes go by.
// Throughput:
//   One byte per cycle sustained while no final byte waits for the result
//   slot. A byte is captured in the input stage at its req transaction; from
//   there it updates the state registers, and a final byte also loads the
//   result into the output register. Rate is set by the single pass from
//   the input stage to the state and result registers.
// Reset:
//   Synchronous, active high; clears the position, walker and both valid
//   flags. Header bytes are not cleared, they are always written before use.
// Stall:
//   While rsp_tready is low a pending result holds; the input stage keeps
//   moving non-final bytes and only a final byte waits for the result slot.
// ----------------------------------------------------------------------------
module image_header_dimension_sniffer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [7:0] data_byte, [39:8] file_length
   input  logic        req_tuser,   // [0] mime_supported
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata    // [2:0] status, [34:3] width, [66:35] height,
                                    // [71:67] zero
);

   localparam int HB = ihds_pkg::HEADER_BYTES;

   // ---------------------------------------------------------------- input stage
   logic        s1_valid_ff, s1_valid_in;
   logic [7:0]  s1_byte_ff;
   logic [31:0] s1_len_ff;
   logic        s1_mime_ff;
   logic        s1_fire;

   // ---------------------------------------------------------------- file state
   logic [31:0] pos_ff, pos_in;
   logic [31:0] len_ff;
   logic        mime_ff;
   logic [7:0]  header_ff [HB];

   ihds_pkg::jpeg_phase_type phase_ff, phase_in, phase_cur;
   logic [32:0] target_ff, target_in, target_cur;
   logic [15:0] seg_ff, seg_in, seg_cur;
   logic [7:0]  marker_ff, marker_in, marker_cur;
   ihds_pkg::jpeg_kind_type  kind_ff, kind_in, kind_cur;
   logic [15:0] jw_ff, jw_in, jw_cur;
   logic [15:0] jh_ff, jh_in, jh_cur;

   // ---------------------------------------------------------------- result
   logic                 rsp_valid_ff, rsp_valid_in;
   ihds_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [31:0]          rsp_w_ff, rsp_w_in;
   logic [31:0]          rsp_h_ff, rsp_h_in;

   // ---------------------------------------------------------------- per-byte view
   logic        first;
   logic [31:0] n;
   logic        mime;
   logic        empty;
   logic        last_byte;
   logic [32:0] p33, n33, i33, seg_end;
   logic [32:0] sof_off;
   logic        search_end;
   logic [15:0] seg_full;
   logic [7:0]  b;

   assign b     = s1_byte_ff;
   assign first = (pos_ff == 32'd0);
   assign n     = first ? s1_len_ff : len_ff;
   assign mime  = first ? s1_mime_ff : mime_ff;
   assign empty = first && (n == 32'd0);

   assign p33        = {1'b0, pos_ff};
   assign n33        = {1'b0, n};
   assign i33        = p33 - 33'd1;
   assign last_byte  = (p33 + 33'd1) >= n33;
   assign search_end = (p33 + 33'd9) >= n33;
   assign seg_full   = {seg_cur[15:8], b};
   assign seg_end    = i33 + {17'd0, seg_full};
   assign sof_off    = target_cur - p33;

   // A new file restarts the walker from its reset values
   always_comb begin
      if (first) begin
         phase_cur  = ihds_pkg::PH_IDLE;
         target_cur = '0;
         seg_cur    = '0;
         marker_cur = '0;
         kind_cur   = ihds_pkg::KIND_NONE;
         jw_cur     = '0;
         jh_cur     = '0;
      end else begin
         phase_cur  = phase_ff;
         target_cur = target_ff;
         seg_cur    = seg_ff;
         marker_cur = marker_ff;
         kind_cur   = kind_ff;
         jw_cur     = jw_ff;
         jh_cur     = jh_ff;
      end
   end

   // ---------------------------------------------------------------- walker next state
   always_comb begin
      phase_in = phase_cur;
      unique case (phase_cur)
         ihds_pkg::PH_IDLE: begin
            if (pos_ff == 32'd1) begin
               phase_in = (header_ff[0] == ihds_pkg::MARKER_PREFIX &&
                           b == ihds_pkg::MARKER_SOI && n >= 32'd4) ?
                          ihds_pkg::PH_SEARCH : ihds_pkg::PH_DONE;
            end
         end
         ihds_pkg::PH_SEARCH: begin
            if (search_end) phase_in = ihds_pkg::PH_DONE;
            else if (b == ihds_pkg::MARKER_PREFIX) phase_in = ihds_pkg::PH_FFRUN;
         end
         ihds_pkg::PH_FFRUN: begin
            if (b == ihds_pkg::MARKER_PREFIX) phase_in = ihds_pkg::PH_FFRUN;
            else if (b == ihds_pkg::MARKER_SOI || b == ihds_pkg::MARKER_EOI)
               phase_in = ihds_pkg::PH_SEARCH;
            else if ((p33 + 33'd2) >= n33) phase_in = ihds_pkg::PH_DONE;
            else phase_in = ihds_pkg::PH_LENHI;
         end
         ihds_pkg::PH_LENHI: phase_in = ihds_pkg::PH_LENLO;
         ihds_pkg::PH_LENLO: begin
            if (seg_full < 16'd2 || seg_end > n33) phase_in = ihds_pkg::PH_DONE;
            else if (ihds_pkg::is_sof(marker_cur) && seg_full >= 16'd7)
               phase_in = ihds_pkg::PH_SOF;
            else phase_in = ihds_pkg::PH_SKIP;
         end
         ihds_pkg::PH_SKIP: begin
            // Segment over: this byte is searched like any other
            if (p33 == target_cur) begin
               if (search_end) phase_in = ihds_pkg::PH_DONE;
               else if (b == ihds_pkg::MARKER_PREFIX) phase_in = ihds_pkg::PH_FFRUN;
               else phase_in = ihds_pkg::PH_SEARCH;
            end
         end
         ihds_pkg::PH_SOF: begin
            if (sof_off == 33'd0) phase_in = ihds_pkg::PH_DONE;
         end
         ihds_pkg::PH_DONE: phase_in = ihds_pkg::PH_DONE;
         default: phase_in = ihds_pkg::PH_DONE;
      endcase
   end

   // ---------------------------------------------------------------- walker outputs
   always_comb begin
      target_in = target_cur;
      seg_in    = seg_cur;
      marker_in = marker_cur;
      kind_in   = kind_cur;
      jw_in     = jw_cur;
      jh_in     = jh_cur;
      unique case (phase_cur)
         ihds_pkg::PH_FFRUN: begin
            if (b != ihds_pkg::MARKER_PREFIX) marker_in = b;
         end
         ihds_pkg::PH_LENHI: seg_in = {b, 8'd0};
         ihds_pkg::PH_LENLO: begin
            seg_in = seg_full;
            if (seg_full >= 16'd2 && seg_end <= n33) begin
               if (ihds_pkg::is_sof(marker_cur) && seg_full >= 16'd7) begin
                  target_in = i33 + 33'd6;
                  kind_in   = ihds_pkg::KIND_NONE;
                  jw_in     = '0;
                  jh_in     = '0;
               end else begin
                  target_in = seg_end;
               end
            end
         end
         ihds_pkg::PH_SOF: begin
            // Frame header: precision, height hi/lo, width hi/lo
            if (sof_off == 33'd3) jh_in[15:8] = b;
            else if (sof_off == 33'd2) jh_in[7:0] = b;
            else if (sof_off == 33'd1) jw_in[15:8] = b;
            else if (sof_off == 33'd0) begin
               jw_in[7:0] = b;
               kind_in = ({jw_cur[15:8], b} == 16'd0 || jh_cur == 16'd0) ?
                         ihds_pkg::KIND_ZERO : ihds_pkg::KIND_OK;
            end
         end
         ihds_pkg::PH_IDLE, ihds_pkg::PH_SEARCH, ihds_pkg::PH_SKIP,
         ihds_pkg::PH_DONE: ;
         default: ;
      endcase
   end

   // ---------------------------------------------------------------- format decision
   logic [7:0] hv [HB];

   always_comb begin
      for (int k = 0; k < HB; k++) begin
         hv[k] = (pos_ff == 32'(k)) ? b : header_ff[k];
      end
   end

   logic is_png, is_gif, is_webp;

   assign is_png = (n >= 32'd24) && hv[0] == 8'h89 && hv[1] == 8'h50 && hv[2] == 8'h4E &&
                   hv[3] == 8'h47 && hv[4] == 8'h0D && hv[5] == 8'h0A &&
                   hv[6] == 8'h1A && hv[7] == 8'h0A;
   // "GIF87a" or "GIF89a"
   assign is_gif = (n >= 32'd10) && hv[0] == 8'h47 && hv[1] == 8'h49 && hv[2] == 8'h46 &&
                   hv[3] == 8'h38 && (hv[4] == 8'h37 || hv[4] == 8'h39) && hv[5] == 8'h61;
   // "RIFF" .... "WEBP" "VP8X"
   assign is_webp = (n >= 32'd30) && hv[0] == 8'h52 && hv[1] == 8'h49 &&
                    hv[2] == 8'h46 && hv[3] == 8'h46 && hv[8] == 8'h57 &&
                    hv[9] == 8'h45 && hv[10] == 8'h42 && hv[11] == 8'h50 &&
                    hv[12] == 8'h56 && hv[13] == 8'h50 && hv[14] == 8'h38 &&
                    hv[15] == 8'h58;

   always_comb begin
      logic [31:0] w, h;
      ihds_pkg::status_type st;
      w  = '0;
      h  = '0;
      st = ihds_pkg::STATUS_OK;
      if (empty) begin
         st = ihds_pkg::STATUS_EMPTY;
      end else if (is_png) begin
         w  = {hv[16], hv[17], hv[18], hv[19]};
         h  = {hv[20], hv[21], hv[22], hv[23]};
         st = (w == 32'd0 || h == 32'd0) ? ihds_pkg::STATUS_PNG_ZERO : ihds_pkg::STATUS_OK;
      end else if (is_gif) begin
         w  = {16'd0, hv[7], hv[6]};
         h  = {16'd0, hv[9], hv[8]};
         st = (w == 32'd0 || h == 32'd0) ? ihds_pkg::STATUS_GIF_ZERO : ihds_pkg::STATUS_OK;
      end else if (is_webp) begin
         // Stored as size minus one, so never zero
         w  = {8'd0, hv[26], hv[25], hv[24]} + 32'd1;
         h  = {8'd0, hv[29], hv[28], hv[27]} + 32'd1;
      end else begin
         case (kind_in)
            ihds_pkg::KIND_OK: begin
               w = {16'd0, jw_in};
               h = {16'd0, jh_in};
            end
            ihds_pkg::KIND_ZERO: st = ihds_pkg::STATUS_JPEG_ZERO;
            default: st = mime ? ihds_pkg::STATUS_UNPARSED : ihds_pkg::STATUS_UNSUPPORTED;
         endcase
      end
      if (st != ihds_pkg::STATUS_OK) begin
         w = '0;
         h = '0;
      end
      rsp_status_in = st;
      rsp_w_in      = w;
      rsp_h_in      = h;
   end

   // ---------------------------------------------------------------- handshake
   // A final byte needs the result slot; other bytes always move on
   assign s1_fire    = s1_valid_ff && (!last_byte || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_fire;
   assign pos_in     = last_byte ? 32'd0 : pos_ff + 32'd1;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_fire) s1_valid_in = 1'b0;
      if (req_tvalid && req_tready) s1_valid_in = 1'b1;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) rsp_valid_in = 1'b0;
      if (s1_fire && last_byte) rsp_valid_in = 1'b1;
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
         len_ff       <= '0;
         mime_ff      <= 1'b0;
         phase_ff     <= ihds_pkg::PH_IDLE;
         target_ff    <= '0;
         seg_ff       <= '0;
         marker_ff    <= '0;
         kind_ff      <= ihds_pkg::KIND_NONE;
         jw_ff        <= '0;
         jh_ff        <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_fire) begin
            pos_ff  <= pos_in;
            len_ff  <= n;
            mime_ff <= mime;
            if (empty) begin
               // Lone item of an empty file: walker stays at its restart values
               phase_ff  <= phase_cur;
               target_ff <= target_cur;
               seg_ff    <= seg_cur;
               marker_ff <= marker_cur;
               kind_ff   <= kind_cur;
               jw_ff     <= jw_cur;
               jh_ff     <= jh_cur;
            end else begin
               phase_ff  <= phase_in;
               target_ff <= target_in;
               seg_ff    <= seg_in;
               marker_ff <= marker_in;
               kind_ff   <= kind_in;
               jw_ff     <= jw_in;
               jh_ff     <= jh_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_byte_ff <= req_tdata[7:0];
         s1_len_ff  <= req_tdata[39:8];
         s1_mime_ff <= req_tuser;
      end
      if (s1_fire && !empty && pos_ff < 32'(HB)) begin
         header_ff[pos_ff[4:0]] <= b;
      end
      if (s1_fire && last_byte) begin
         rsp_status_ff <= rsp_status_in;
         rsp_w_ff      <= rsp_w_in;
         rsp_h_ff      <= rsp_h_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_h_ff, rsp_w_ff, rsp_status_ff};

   // ---------------------------------------------------------------- assertions
   a_final_gives_result: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && last_byte) |=> rsp_valid_ff)
      else $error("final byte did not load a result");

   a_final_rewinds: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && last_byte) |=> (pos_ff == 32'd0))
      else $error("position not rewound after final byte");

   a_dims_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ihds_pkg::STATUS_OK) |->
      (rsp_w_ff == 32'd0 && rsp_h_ff == 32'd0))
      else $error("nonzero dimensions with error status");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_fire) |=> (s1_valid_ff && $stable(s1_len_ff) &&
      $stable(s1_byte_ff)))
      else $error("input stage lost a pending byte");

   a_done_sticks: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && !first && phase_ff == ihds_pkg::PH_DONE) |=>
      (phase_ff == ihds_pkg::PH_DONE))
      else $error("walker left done state within a file");

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the image header dimension sniffer. Whole files
// (PNG, GIF, WebP VP8X, JPEG, noise and empty) are streamed in one byte per
// transaction. A table of directed files runs first, then randomly built
// files with flaws. A byte-level model of the sniffer predicts each result
// that the directed table does not give, and the result channel is checked
// field by field under varied valid/ready pressure.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int  TIMEOUT_NS   = 2_000_000;
   localparam int  DIR_ROWS     = 15;
   localparam int  RANDOM_BYTES = 540;
   localparam int  MIN_FILES    = 30;
   localparam int  LONG_HOLD    = 300;
   localparam int  DRAIN_LIMIT  = 10000;
   localparam int  TAIL_CYCLES  = 10;
   localparam logic [63:0] PNG_SIGNATURE = 64'h89504E470D0A1A0A;

   typedef enum logic [2:0] {
      FORM_EMPTY, FORM_NOISE, FORM_PNG, FORM_GIF, FORM_WEBP, FORM_JPEG
   } file_form_type;

   typedef struct packed {
      ihds_pkg::status_type status;
      logic [31:0] width;
      logic [31:0] height;
   } dims_type;

   typedef struct {
      logic [7:0]  data;
      logic [31:0] flen;
      logic        mime;
      bit          has_exp;
      dims_type    exp;
   } byte_item_type;

   // form, width, height, tail (length for noise), mime, typed, status, w, h
   typedef struct packed {
      file_form_type        form;
      logic [31:0]          w;
      logic [31:0]          h;
      logic [7:0]           tail;
      logic                 mime;
      logic                 typed;
      ihds_pkg::status_type exp_st;
      logic [31:0]          exp_w;
      logic [31:0]          exp_h;
   } dir_row_type;

   dir_row_type dir_rows [DIR_ROWS] = '{
      '{FORM_EMPTY, 32'd0, 32'd0, 8'd0, 1'b1, 1'b1, ihds_pkg::STATUS_EMPTY,
        32'd0, 32'd0},
      '{FORM_NOISE, 32'd0, 32'd0, 8'd1, 1'b0, 1'b1, ihds_pkg::STATUS_UNSUPPORTED,
        32'd0, 32'd0},
      '{FORM_NOISE, 32'd0, 32'd0, 8'd1, 1'b1, 1'b1, ihds_pkg::STATUS_UNPARSED,
        32'd0, 32'd0},
      '{FORM_PNG, 32'd1, 32'd1, 8'd0, 1'b1, 1'b1, ihds_pkg::STATUS_OK, 32'd1, 32'd1},
      '{FORM_PNG, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'd3, 1'b0, 1'b1, ihds_pkg::STATUS_OK,
        32'hFFFFFFFF, 32'hFFFFFFFF},
      '{FORM_PNG, 32'd0, 32'd5, 8'd2, 1'b1, 1'b1, ihds_pkg::STATUS_PNG_ZERO,
        32'd0, 32'd0},
      '{FORM_GIF, 32'hFFFF, 32'd1, 8'd0, 1'b1, 1'b1, ihds_pkg::STATUS_OK,
        32'hFFFF, 32'd1},
      '{FORM_GIF, 32'd3, 32'd0, 8'd4, 1'b0, 1'b1, ihds_pkg::STATUS_GIF_ZERO,
        32'd0, 32'd0},
      '{FORM_WEBP, 32'd1, 32'd1, 8'd0, 1'b1, 1'b1, ihds_pkg::STATUS_OK, 32'd1, 32'd1},
      '{FORM_WEBP, 32'h0100_0000, 32'h0100_0000, 8'd2, 1'b1, 1'b1, ihds_pkg::STATUS_OK,
        32'h0100_0000, 32'h0100_0000},
      '{FORM_JPEG, 32'd640, 32'd480, 8'd12, 1'b1, 1'b1, ihds_pkg::STATUS_OK,
        32'd640, 32'd480},
      '{FORM_JPEG, 32'd0, 32'd100, 8'd12, 1'b1, 1'b1, ihds_pkg::STATUS_JPEG_ZERO,
        32'd0, 32'd0},
      '{FORM_JPEG, 32'd1, 32'd1, 8'd0, 1'b0, 1'b0, ihds_pkg::STATUS_OK, 32'd0, 32'd0},
      '{FORM_NOISE, 32'd0, 32'd0, 8'd40, 1'b0, 1'b0, ihds_pkg::STATUS_OK,
        32'd0, 32'd0},
      '{FORM_GIF, 32'd320, 32'd200, 8'd9, 1'b0, 1'b0, ihds_pkg::STATUS_OK,
        32'd0, 32'd0}
   };

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;
   logic        req_tuser  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;

   byte_item_type byte_stream [$];
   dims_type      dims_due [$];
   logic [7:0]    file_bytes [$];
   byte_item_type shown;
   bit            made;
   dims_type      made_dims;
   dims_type      head_dims;

   int src_idle_pct  = 0;
   int snk_stall_pct = 0;
   bit hold_ask      = 1'b0;
   int hold_left     = 0;
   int errors        = 0;
   int queued_bytes  = 0;
   int queued_files  = 0;

   // sniffer model state
   logic [31:0]    at_offset = '0;
   logic [7:0]     hdr_kept [ihds_pkg::HEADER_BYTES] = '{default: 8'h00};
   logic [31:0]    kept_len  = '0;
   logic           kept_mime = 1'b0;
   ihds_pkg::jpeg_phase_type jphase = ihds_pkg::PH_IDLE;
   longint unsigned jtarget  = 0;
   logic [15:0]    seg_len   = '0;
   logic [7:0]     last_marker = '0;
   ihds_pkg::jpeg_kind_type jkind = ihds_pkg::KIND_NONE;
   logic [15:0]    jw        = '0;
   logic [15:0]    jh        = '0;

   image_header_dimension_sniffer_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   task automatic note_mismatch(input string msg);
      errors++;
      if (errors <= 200) $display("[%0t] mismatch: %s", $time, msg);
   endtask

   // ---------------------------------------------------------------- model

   function automatic bit starts_frame(input logic [7:0] m);
      return m[7:4] == 4'hC &&
             !(m inside {ihds_pkg::MARKER_DHT, ihds_pkg::MARKER_JPG, ihds_pkg::MARKER_DAC});
   endfunction

   task automatic hunt_prefix(input longint unsigned p, input logic [7:0] b,
                              input longint unsigned n);
      if (p + 9 >= n) jphase = ihds_pkg::PH_DONE;
      else if (b == ihds_pkg::MARKER_PREFIX) jphase = ihds_pkg::PH_FFRUN;
   endtask

   task automatic walk_markers(input longint unsigned p, input logic [7:0] b,
                               input longint unsigned n);
      longint unsigned i;
      longint unsigned off;
      case (jphase)
         ihds_pkg::PH_IDLE: begin
            if (p == 1)
               jphase = (hdr_kept[0] == ihds_pkg::MARKER_PREFIX &&
                         b == ihds_pkg::MARKER_SOI && n >= 4) ?
                        ihds_pkg::PH_SEARCH : ihds_pkg::PH_DONE;
         end
         ihds_pkg::PH_SEARCH: hunt_prefix(p, b, n);
         ihds_pkg::PH_FFRUN: begin
            if (b != ihds_pkg::MARKER_PREFIX) begin
               last_marker = b;
               if (b == ihds_pkg::MARKER_SOI || b == ihds_pkg::MARKER_EOI)
                  jphase = ihds_pkg::PH_SEARCH;
               else if (p + 2 >= n) jphase = ihds_pkg::PH_DONE;
               else jphase = ihds_pkg::PH_LENHI;
            end
         end
         ihds_pkg::PH_LENHI: begin
            seg_len = {b, 8'h00};
            jphase  = ihds_pkg::PH_LENLO;
         end
         ihds_pkg::PH_LENLO: begin
            seg_len[7:0] = b;
            i = p - 1;
            if (seg_len < 2 || i + seg_len > n) begin
               jphase = ihds_pkg::PH_DONE;
            end else if (starts_frame(last_marker) && seg_len >= 7) begin
               jtarget = i + 6;
               jkind   = ihds_pkg::KIND_NONE;
               jw      = '0;
               jh      = '0;
               jphase  = ihds_pkg::PH_SOF;
            end else begin
               jtarget = i + seg_len;
               jphase  = ihds_pkg::PH_SKIP;
            end
         end
         ihds_pkg::PH_SKIP: begin
            if (p == jtarget) begin
               jphase = ihds_pkg::PH_SEARCH;
               hunt_prefix(p, b, n);
            end
         end
         ihds_pkg::PH_SOF: begin
            off = jtarget - p;
            // frame header: precision, height, width, all big endian
            if (off == 3) jh[15:8] = b;
            else if (off == 2) jh[7:0] = b;
            else if (off == 1) jw[15:8] = b;
            else if (off == 0) begin
               jw[7:0] = b;
               jkind   = (jw == 0 || jh == 0) ? ihds_pkg::KIND_ZERO : ihds_pkg::KIND_OK;
               jphase  = ihds_pkg::PH_DONE;
            end
         end
         default: ;
      endcase
   endtask

   function automatic dims_type judge_file();
      dims_type r;
      longint unsigned n;
      r = '0;
      n = kept_len;
      if (n >= 24 && {hdr_kept[0], hdr_kept[1], hdr_kept[2], hdr_kept[3], hdr_kept[4],
                      hdr_kept[5], hdr_kept[6], hdr_kept[7]} == PNG_SIGNATURE) begin
         r.width  = {hdr_kept[16], hdr_kept[17], hdr_kept[18], hdr_kept[19]};
         r.height = {hdr_kept[20], hdr_kept[21], hdr_kept[22], hdr_kept[23]};
         r.status = (r.width == 0 || r.height == 0) ? ihds_pkg::STATUS_PNG_ZERO :
                                                      ihds_pkg::STATUS_OK;
      end else if (n >= 10 &&
                   {hdr_kept[0], hdr_kept[1], hdr_kept[2], hdr_kept[3]} == "GIF8" &&
                   (hdr_kept[4] == "7" || hdr_kept[4] == "9") && hdr_kept[5] == "a") begin
         r.width  = {16'h0, hdr_kept[7], hdr_kept[6]};
         r.height = {16'h0, hdr_kept[9], hdr_kept[8]};
         r.status = (r.width == 0 || r.height == 0) ? ihds_pkg::STATUS_GIF_ZERO :
                                                      ihds_pkg::STATUS_OK;
      end else if (n >= 30 &&
                   {hdr_kept[0], hdr_kept[1], hdr_kept[2], hdr_kept[3]} == "RIFF" &&
                   {hdr_kept[8], hdr_kept[9], hdr_kept[10], hdr_kept[11]} == "WEBP" &&
                   {hdr_kept[12], hdr_kept[13], hdr_kept[14], hdr_kept[15]} == "VP8X") begin
         // stored as size minus one, so never zero
         r.width  = {8'h0, hdr_kept[26], hdr_kept[25], hdr_kept[24]} + 32'd1;
         r.height = {8'h0, hdr_kept[29], hdr_kept[28], hdr_kept[27]} + 32'd1;
         r.status = ihds_pkg::STATUS_OK;
      end else if (jkind == ihds_pkg::KIND_OK) begin
         r.width  = {16'h0, jw};
         r.height = {16'h0, jh};
         r.status = ihds_pkg::STATUS_OK;
      end else if (jkind == ihds_pkg::KIND_ZERO) begin
         r.status = ihds_pkg::STATUS_JPEG_ZERO;
      end else begin
         r.status = kept_mime ? ihds_pkg::STATUS_UNPARSED : ihds_pkg::STATUS_UNSUPPORTED;
      end
      if (r.status != ihds_pkg::STATUS_OK) begin
         r.width  = '0;
         r.height = '0;
      end
      return r;
   endfunction

   // Advance the model by one accepted byte; got is set when a file ends.
   task automatic sniff_byte(input logic [7:0] b, input logic [31:0] flen, input logic mime,
                             output bit got, output dims_type r);
      longint unsigned p;
      got = 1'b0;
      r   = '0;
      if (at_offset == 0) begin
         kept_len    = flen;
         kept_mime   = mime;
         jphase      = ihds_pkg::PH_IDLE;
         jtarget     = 0;
         seg_len     = '0;
         last_marker = '0;
         jkind       = ihds_pkg::KIND_NONE;
         jw          = '0;
         jh          = '0;
      end
      if (at_offset == 0 && flen == 0) begin
         got      = 1'b1;
         r.status = ihds_pkg::STATUS_EMPTY;
      end else begin
         p = at_offset;
         if (p < ihds_pkg::HEADER_BYTES) hdr_kept[5'(p)] = b;
         walk_markers(p, b, kept_len);
         if (p + 1 >= kept_len) begin
            got       = 1'b1;
            r         = judge_file();
            at_offset = '0;
         end else begin
            at_offset = 32'(p + 1);
         end
      end
   endtask

   // ----------------------------------------------------------- file builder

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) file_bytes.push_back(s[i]);
   endtask

   task automatic push_word(input logic [31:0] v);
      for (int i = 3; i >= 0; i--) file_bytes.push_back(v[8*i +: 8]);
   endtask

   task automatic push_marker(input logic [7:0] m, input logic [15:0] len);
      repeat ($urandom_range(1, 3)) file_bytes.push_back(ihds_pkg::MARKER_PREFIX);
      file_bytes.push_back(m);
      file_bytes.push_back(len[15:8]);
      file_bytes.push_back(len[7:0]);
   endtask

   function automatic logic [31:0] pick_dim();
      case ($urandom_range(5))
         0: return 32'd0;
         1: return 32'hFFFFFFFF;
         2: return 32'd1;
         default: return $urandom;
      endcase
   endfunction

   // Build one file into file_bytes; rnd adds random structure and flaws.
   task automatic make_file(input file_form_type form, input logic [31:0] w,
                            input logic [31:0] h, input int tail, input bit rnd);
      logic [23:0] sw, sh;
      logic [15:0] seg_l;
      logic [7:0]  m;
      int          k;
      file_bytes.delete();
      sw = 24'(w - 32'd1);
      sh = 24'(h - 32'd1);
      case (form)
         FORM_NOISE: repeat (tail) file_bytes.push_back(8'($urandom));
         FORM_PNG: begin
            push_word(PNG_SIGNATURE[63:32]);
            push_word(PNG_SIGNATURE[31:0]);
            push_word(32'h0000000D);
            push_text("IHDR");
            push_word(w);
            push_word(h);
         end
         FORM_GIF: begin
            push_text((rnd && $urandom_range(1) == 1) ? "GIF87a" : "GIF89a");
            file_bytes.push_back(w[7:0]);
            file_bytes.push_back(w[15:8]);
            file_bytes.push_back(h[7:0]);
            file_bytes.push_back(h[15:8]);
         end
         FORM_WEBP: begin
            push_text("RIFF");
            push_word($urandom);
            push_text("WEBPVP8X");
            push_word($urandom);
            push_word($urandom);
            for (k = 0; k < 3; k++) file_bytes.push_back(sw[8*k +: 8]);
            for (k = 0; k < 3; k++) file_bytes.push_back(sh[8*k +: 8]);
         end
         FORM_JPEG: begin
            file_bytes.push_back(ihds_pkg::MARKER_PREFIX);
            file_bytes.push_back(ihds_pkg::MARKER_SOI);
            if (!rnd) begin
               // APP0 of 16, then a baseline frame header of 17
               push_word({ihds_pkg::MARKER_PREFIX, 8'hE0, 16'd16});
               repeat (14) file_bytes.push_back(8'($urandom));
               push_word({ihds_pkg::MARKER_PREFIX, 8'hC0, 16'd17});
               seg_l = 16'd17;
            end else begin
               repeat ($urandom_range(3)) begin
                  case ($urandom_range(4))
                     0: begin
                        file_bytes.push_back(ihds_pkg::MARKER_PREFIX);
                        file_bytes.push_back($urandom_range(1) ? ihds_pkg::MARKER_EOI :
                                                                 ihds_pkg::MARKER_SOI);
                     end
                     1: repeat ($urandom_range(1, 3))
                           file_bytes.push_back(8'($urandom_range(254)));
                     default: begin
                        case ($urandom_range(3))
                           0: m = {4'hE, 4'($urandom)};
                           1: m = ($urandom_range(1) == 1) ? ihds_pkg::MARKER_DHT :
                                  (($urandom_range(1) == 1) ? ihds_pkg::MARKER_JPG :
                                                              ihds_pkg::MARKER_DAC);
                           2: m = 8'hDB;
                           default: m = 8'hFE;
                        endcase
                        seg_l = 16'($urandom_range(2, 12));
                        push_marker(m, seg_l);
                        repeat (seg_l - 2) file_bytes.push_back(8'($urandom));
                     end
                  endcase
               end
               case ($urandom_range(5))
                  0: seg_l = 16'($urandom_range(6));           // too short
                  1: seg_l = 16'hFF00 | 16'($urandom_range(255)); // past the end
                  default: seg_l = 16'(8 + 3 * $urandom_range(1, 3));
               endcase
               push_marker({4'hC, 4'($urandom)}, seg_l);
            end
            file_bytes.push_back(8'd8);
            file_bytes.push_back(h[15:8]);
            file_bytes.push_back(h[7:0]);
            file_bytes.push_back(w[15:8]);
            file_bytes.push_back(w[7:0]);
            if (seg_l > 7) repeat ((seg_l - 7 > 12) ? 12 : seg_l - 7)
               file_bytes.push_back(8'($urandom));
         end
         default: ;
      endcase
      if (form != FORM_NOISE && form != FORM_EMPTY)
         repeat (tail) file_bytes.push_back(8'($urandom));
      if (rnd && file_bytes.size() != 0) begin
         // flip a header bit now and then, and cut some files short
         if ($urandom_range(9) == 0) begin
            k = $urandom_range((file_bytes.size() > 16) ? 15 : file_bytes.size() - 1);
            file_bytes[k] = file_bytes[k] ^ 8'(1 << $urandom_range(7));
         end
         if ($urandom_range(7) == 0 && file_bytes.size() > 1)
            repeat ($urandom_range(1, file_bytes.size() - 1)) void'(file_bytes.pop_back());
      end
   endtask

   // Turn file_bytes into transactions. Length and mime matter on the first
   // byte only, so the others carry random values there.
   task automatic queue_file(input logic mime, input bit typed, input dims_type want);
      byte_item_type it;
      int            k;
      it.exp = want;
      if (file_bytes.size() == 0) begin
         it.data    = 8'($urandom);
         it.flen    = '0;
         it.mime    = mime;
         it.has_exp = typed;
         byte_stream.push_back(it);
         queued_bytes++;
      end else begin
         for (k = 0; k < file_bytes.size(); k++) begin
            it.data    = file_bytes[k];
            it.flen    = (k == 0) ? 32'(file_bytes.size()) : $urandom;
            it.mime    = (k == 0) ? mime : 1'($urandom);
            it.has_exp = typed && (k == file_bytes.size() - 1);
            byte_stream.push_back(it);
            queued_bytes++;
         end
      end
      queued_files++;
   endtask

   // ----------------------------------------------------------------- driver

   // Predict on each accepted byte, then present the next one or idle.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            sniff_byte(shown.data, shown.flen, shown.mime, made, made_dims);
            if (made) dims_due.push_back(shown.has_exp ? shown.exp : made_dims);
         end
         if (!req_tvalid || req_tready) begin
            if (byte_stream.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
               shown = byte_stream.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {shown.flen, shown.data};
               req_tuser  <= shown.mime;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Check each accepted result, then decide ready for the next edge.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (dims_due.size() == 0) begin
               note_mismatch("result with nothing expected");
            end else begin
               head_dims = dims_due.pop_front();
               if (rsp_tdata[2:0] !== head_dims.status)
                  note_mismatch($sformatf("status %0d, want %0d",
                                          rsp_tdata[2:0], head_dims.status));
               if (rsp_tdata[34:3] !== head_dims.width)
                  note_mismatch($sformatf("width %0d, want %0d",
                                          rsp_tdata[34:3], head_dims.width));
               if (rsp_tdata[66:35] !== head_dims.height)
                  note_mismatch($sformatf("height %0d, want %0d",
                                          rsp_tdata[66:35], head_dims.height));
            end
         end
         if (hold_ask) begin
            hold_ask   = 1'b0;
            hold_left  = LONG_HOLD;
            rsp_tready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left  = hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= snk_stall_pct);
         end
      end
   end

   // --------------------------------------------------------------- stimulus

   initial begin : stimulus
      int            k;
      int            phase_now;
      int            phase_next;
      int            base_bytes;
      int            sel;
      file_form_type form;
      dims_type      want;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (k = 0; k < DIR_ROWS; k++) begin
         make_file(dir_rows[k].form, dir_rows[k].w, dir_rows[k].h, dir_rows[k].tail, 1'b0);
         want = '{dir_rows[k].exp_st, dir_rows[k].exp_w, dir_rows[k].exp_h};
         queue_file(dir_rows[k].mime, dir_rows[k].typed, want);
      end

      // hold results back while bytes keep coming, so the input backs up
      hold_ask   = 1'b1;
      phase_now  = 0;
      base_bytes = queued_bytes;
      while (queued_bytes - base_bytes < RANDOM_BYTES || queued_files < MIN_FILES) begin
         phase_next = (queued_bytes - base_bytes) / (RANDOM_BYTES / 4);
         if (phase_next > 3) phase_next = 3;
         if (phase_next != phase_now) begin
            phase_now = phase_next;
            if (phase_now == 2)
               while (byte_stream.size() != 0 || req_tvalid || dims_due.size() != 0)
                  @(negedge clock);
            case (phase_now)
               1: begin src_idle_pct = 82; snk_stall_pct = 0;  end
               2: begin src_idle_pct = 0;  snk_stall_pct = 82; end
               default: begin src_idle_pct = 28; snk_stall_pct = 28; end
            endcase
         end
         while (byte_stream.size() > 48) @(negedge clock);
         sel = $urandom_range(99);
         if (sel < 5) form = FORM_EMPTY;
         else if (sel < 15) form = FORM_NOISE;
         else if (sel < 35) form = FORM_PNG;
         else if (sel < 55) form = FORM_GIF;
         else if (sel < 70) form = FORM_WEBP;
         else form = FORM_JPEG;
         make_file(form, pick_dim(), pick_dim(),
                   (form == FORM_NOISE) ? $urandom_range(1, 40) : $urandom_range(10), 1'b1);
         queue_file(1'($urandom), 1'b0, '0);
      end

      while (byte_stream.size() != 0 || req_tvalid) @(negedge clock);
      for (k = 0; k < DRAIN_LIMIT && dims_due.size() != 0; k++) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (dims_due.size() != 0)
         note_mismatch($sformatf("%0d results never arrived", dims_due.size()));
      if (errors == 0) begin
         $display("[image_header_dimension_sniffer_core] OK");
      end else begin
         $display("[image_header_dimension_sniffer_core] ERROR");
      end
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("[image_header_dimension_sniffer_core] ERROR");
      $finish;
   end

endmodule
